// File: rtl/e2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants
// Payload structures, pipeline depths and the CORDIC arctangent table for
// the Euler angle to quaternion pose core.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int POS_W     = 32;
    localparam int ANGLE_W   = 16;
    localparam int QUAT_W    = 16;
    localparam int CORDIC_N  = 30;
    localparam int CW        = 34;
    localparam int SQRT_N    = 32;
    localparam int QUO_W     = 17;
    localparam int DIV_W     = 48;

    localparam int LAT_CORDIC = CORDIC_N + 1;
    localparam int LAT_QUAT   = 7;
    localparam int LAT_SQRT   = SQRT_N + 1;
    localparam int LAT_DIV    = QUO_W + 2;
    localparam int LAT_TOTAL  = LAT_CORDIC + LAT_QUAT + LAT_SQRT + LAT_DIV;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

    typedef struct packed {
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } t_pose_in;

    typedef struct packed {
        logic signed [POS_W-1:0]  out_x;
        logic signed [POS_W-1:0]  out_y;
        logic signed [POS_W-1:0]  out_z;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_w;
    } t_pose_out;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } t_qraw;

    typedef struct packed {
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
        logic signed [QUAT_W-1:0] w;
    } t_qout;

    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0: v = 34'sh020000000;
            1: v = 34'sh012E4051D;
            2: v = 34'sh009FB385B;
            3: v = 34'sh0051111D4;
            4: v = 34'sh0028B0D43;
            5: v = 34'sh00145D7E1;
            6: v = 34'sh000A2F61E;
            7: v = 34'sh000517C55;
            8: v = 34'sh00028BE53;
            9: v = 34'sh000145F2E;
            10: v = 34'sh0000A2F98;
            11: v = 34'sh0000517CC;
            12: v = 34'sh000028BE6;
            13: v = 34'sh0000145F3;
            14: v = 34'sh00000A2F9;
            15: v = 34'sh00000517C;
            16: v = 34'sh0000028BE;
            17: v = 34'sh00000145F;
            18: v = 34'sh000000A2F;
            19: v = 34'sh000000517;
            20: v = 34'sh00000028B;
            21: v = 34'sh000000145;
            22: v = 34'sh0000000A2;
            23: v = 34'sh000000051;
            24: v = 34'sh000000028;
            25: v = 34'sh000000014;
            26: v = 34'sh00000000A;
            27: v = 34'sh000000005;
            28: v = 34'sh000000002;
            29: v = 34'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/e2q_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_delay: fixed delay line
// Shift register that keeps side data aligned with the arithmetic pipeline.
// ----------------------------------------------------------------------------
module e2q_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_d [DEPTH];

    always_ff @(posedge i_clk) begin
        r_d[0] <= i_data;
        for (int k = 1; k < DEPTH; k++) begin
            r_d[k] <= r_d[k-1];
        end
    end

    assign o_data = r_d[DEPTH-1];

endmodule

// File: rtl/e2q_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_cordic: pipelined half-angle sine and cosine
// Halves a binary angle and rotates a gain-compensated vector through one
// CORDIC step per register stage.
// ----------------------------------------------------------------------------
module e2q_cordic (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] i_angle,
    output logic                             o_valid,
    output logic signed [31:0]               o_cos,
    output logic signed [31:0]               o_sin
);

    localparam int N  = e2q_pkg::CORDIC_N;
    localparam int CW = e2q_pkg::CW;

    logic signed [CW-1:0] r_x [N+1];
    logic signed [CW-1:0] r_y [N+1];
    logic signed [CW-1:0] r_z [N+1];
    logic                 r_v [N+1];
    logic signed [31:0]   s_phase;

    assign s_phase = {i_angle, {(32 - e2q_pkg::ANGLE_W){1'b0}}};

    always_ff @(posedge i_clk) begin
        r_x[0] <= e2q_pkg::CORDIC_GAIN;
        r_y[0] <= '0;
        r_z[0] <= CW'(s_phase >>> 1);
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!r_z[i][CW-1]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - e2q_pkg::atan_q30(i);
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + e2q_pkg::atan_q30(i);
            end
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_cos   = r_x[N][31:0];
    assign o_sin   = r_y[N][31:0];

endmodule

// File: rtl/e2q_quat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_quat: quaternion components and sum of squares
// Forms the ZYX quaternion from the half-angle sines and cosines over four
// multiply stages, then squares and adds the components in three more.
// ----------------------------------------------------------------------------
module e2q_quat (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [31:0] i_cr,
    input  logic signed [31:0] i_sr,
    input  logic signed [31:0] i_cp,
    input  logic signed [31:0] i_sp,
    input  logic signed [31:0] i_cy,
    input  logic signed [31:0] i_sy,
    output logic               o_valid,
    output e2q_pkg::t_qraw     o_q,
    output logic [63:0]        o_sum
);

    logic [6:0]         r_v;
    logic signed [63:0] r_ma, r_mb, r_mc, r_md;
    logic signed [31:0] r1_cr, r1_sr, r2_cr, r2_sr;
    logic signed [31:0] r_a, r_b, r_c, r_d;
    logic signed [63:0] r_pw1, r_pw2, r_px1, r_px2, r_py1, r_py2, r_pz1, r_pz2;
    e2q_pkg::t_qraw     r4_q, r5_q, r6_q, r7_q;
    logic [63:0]        r_s0, r_s1, r_s2, r_s3, r_h0, r_h1, r_sum;
    logic signed [63:0] s_w, s_x, s_y, s_z;

    assign s_w = r_pw1 + r_pw2;
    assign s_x = r_px1 - r_px2;
    assign s_y = r_py1 + r_py2;
    assign s_z = r_pz1 - r_pz2;

    always_ff @(posedge i_clk) begin
        r_ma  <= i_cp * i_cy;
        r_mb  <= i_sp * i_sy;
        r_mc  <= i_sp * i_cy;
        r_md  <= i_cp * i_sy;
        r1_cr <= i_cr;
        r1_sr <= i_sr;

        r_a   <= r_ma[61:30];
        r_b   <= r_mb[61:30];
        r_c   <= r_mc[61:30];
        r_d   <= r_md[61:30];
        r2_cr <= r1_cr;
        r2_sr <= r1_sr;

        r_pw1 <= r2_cr * r_a;
        r_pw2 <= r2_sr * r_b;
        r_px1 <= r2_sr * r_a;
        r_px2 <= r2_cr * r_b;
        r_py1 <= r2_cr * r_c;
        r_py2 <= r2_sr * r_d;
        r_pz1 <= r2_cr * r_d;
        r_pz2 <= r2_sr * r_c;

        r4_q.w <= s_w[61:30];
        r4_q.x <= s_x[61:30];
        r4_q.y <= s_y[61:30];
        r4_q.z <= s_z[61:30];

        r_s0 <= 64'(r4_q.w * r4_q.w);
        r_s1 <= 64'(r4_q.x * r4_q.x);
        r_s2 <= 64'(r4_q.y * r4_q.y);
        r_s3 <= 64'(r4_q.z * r4_q.z);
        r5_q <= r4_q;

        r_h0 <= r_s0 + r_s1;
        r_h1 <= r_s2 + r_s3;
        r6_q <= r5_q;

        r_sum <= r_h0 + r_h1;
        r7_q  <= r6_q;

        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    assign o_valid = r_v[6];
    assign o_q     = r7_q;
    assign o_sum   = r_sum;

endmodule

// File: rtl/e2q_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_isqrt: pipelined integer square root
// Digit-by-digit square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module e2q_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [63:0] i_sum,
    output logic        o_valid,
    output logic [31:0] o_root
);

    localparam int N = e2q_pkg::SQRT_N;

    logic [63:0] r_rem  [N+1];
    logic [63:0] r_root [N+1];
    logic        r_v    [N+1];

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_sum;
        r_root[0] <= '0;
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] s_trial;
        assign s_trial = r_root[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (r_rem[k] >= s_trial) begin
                r_rem[k+1]  <= r_rem[k] - s_trial;
                r_root[k+1] <= (r_root[k] >> 1) + BIT;
            end else begin
                r_rem[k+1]  <= r_rem[k];
                r_root[k+1] <= r_root[k] >> 1;
            end
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_root  = r_root[N][31:0];

endmodule

// File: rtl/e2q_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_div: normalising divider
// Divides each quaternion magnitude by the norm with rounding, one quotient
// bit per stage in four lanes, then restores signs and saturates.
// ----------------------------------------------------------------------------
module e2q_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  e2q_pkg::t_qraw i_q,
    input  logic [31:0]    i_norm,
    output logic           o_valid,
    output e2q_pkg::t_qout o_q
);

    localparam int QB = e2q_pkg::QUO_W;
    localparam int DW = e2q_pkg::DIV_W;
    localparam int QW = e2q_pkg::QUAT_W;
    localparam logic [QB-1:0] MAXPOS = QB'((1 << (QW - 1)) - 1);
    localparam logic [QB-1:0] MAXNEG = QB'(1 << (QW - 1));

    logic signed [31:0] s_q [4];
    logic [DW-1:0]      r_rem  [QB+1][4];
    logic [QB-1:0]      r_quo  [QB+1][4];
    logic               r_neg  [QB+1][4];
    logic [31:0]        r_den  [QB+1];
    logic               r_v    [QB+1];
    logic [QW-1:0]      s_res  [4];
    e2q_pkg::t_qout     r_out;
    logic               r_ov;

    assign s_q[0] = i_q.x;
    assign s_q[1] = i_q.y;
    assign s_q[2] = i_q.z;
    assign s_q[3] = i_q.w;

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [31:0] s_mag;
        assign s_mag = s_q[l][31] ? 32'(-s_q[l]) : s_q[l];

        always_ff @(posedge i_clk) begin
            r_rem[0][l] <= (DW'(s_mag) << (QW - 1)) + DW'(i_norm >> 1);
            r_quo[0][l] <= '0;
            r_neg[0][l] <= s_q[l][31];
        end

        for (genvar k = 0; k < QB; k++) begin : g_step
            logic [DW-1:0] s_ds;
            assign s_ds = DW'(r_den[k]) << (QB - 1 - k);
            always_ff @(posedge i_clk) begin
                if (r_rem[k][l] >= s_ds) begin
                    r_rem[k+1][l] <= r_rem[k][l] - s_ds;
                    r_quo[k+1][l] <= {r_quo[k][l][QB-2:0], 1'b1};
                end else begin
                    r_rem[k+1][l] <= r_rem[k][l];
                    r_quo[k+1][l] <= {r_quo[k][l][QB-2:0], 1'b0};
                end
                r_neg[k+1][l] <= r_neg[k][l];
            end
        end

        always_comb begin
            if (!r_neg[QB][l]) begin
                s_res[l] = (r_quo[QB][l] > MAXPOS) ? MAXPOS[QW-1:0] : r_quo[QB][l][QW-1:0];
            end else if (r_quo[QB][l] > MAXNEG) begin
                s_res[l] = QW'(-MAXNEG);
            end else begin
                s_res[l] = QW'(-r_quo[QB][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_den[0] <= i_norm;
        for (int k = 0; k < QB; k++) begin
            r_den[k+1] <= r_den[k];
        end
        if (r_den[QB] == '0) begin
            r_out.x <= '0;
            r_out.y <= '0;
            r_out.z <= '0;
            r_out.w <= MAXPOS[QW-1:0];
        end else begin
            r_out.x <= s_res[0];
            r_out.y <= s_res[1];
            r_out.z <= s_res[2];
            r_out.w <= s_res[3];
        end
        if (!i_rst_n) begin
            for (int k = 0; k <= QB; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 0; k < QB; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_ov <= r_v[QB];
        end
    end

    assign o_valid = r_ov;
    assign o_q     = r_out;

endmodule

// File: rtl/euler_to_quaternion_pose_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_pose_core: pose conversion from Euler angles
// Passes the position through and turns roll, pitch and yaw into a unit
// quaternion in ZYX order.
// ----------------------------------------------------------------------------
// The core takes one item in every clock cycle in which busy is low; each
// item passes through 31 CORDIC stages, 7 multiply and square stages,
// 33 square root stages and 19 divider stages. Results are strobed for a
// single cycle and cannot be held off by the receiver. Busy is high only
// while reset is applied and in the cycle after it.
module euler_to_quaternion_pose_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  e2q_pkg::t_pose_in i_pose,
    output logic              o_busy,
    output logic              o_valid,
    output e2q_pkg::t_pose_out o_pose
);

    localparam int PW = 3 * e2q_pkg::POS_W;

    logic                r_busy;
    logic                s_accept;
    logic                s_cv_r, s_cv_p, s_cv_y;
    logic signed [31:0]  s_cr, s_sr, s_cp, s_sp, s_cy, s_sy;
    logic                s_qv;
    e2q_pkg::t_qraw      s_q, s_q_dly;
    logic [63:0]         s_sum;
    logic                s_rv;
    logic [31:0]         s_root;
    logic                s_dv;
    e2q_pkg::t_qout      s_qo;
    logic [PW-1:0]       s_pos_dly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy   = r_busy | ~i_rst_n;
    assign s_accept = i_start & ~o_busy;

    e2q_cordic u_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_accept),
        .i_angle(i_pose.roll_angle), .o_valid(s_cv_r), .o_cos(s_cr), .o_sin(s_sr)
    );

    e2q_cordic u_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_accept),
        .i_angle(i_pose.pitch_angle), .o_valid(s_cv_p), .o_cos(s_cp), .o_sin(s_sp)
    );

    e2q_cordic u_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_accept),
        .i_angle(i_pose.yaw_angle), .o_valid(s_cv_y), .o_cos(s_cy), .o_sin(s_sy)
    );

    e2q_quat u_quat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_cv_r & s_cv_p & s_cv_y),
        .i_cr(s_cr), .i_sr(s_sr), .i_cp(s_cp), .i_sp(s_sp), .i_cy(s_cy), .i_sy(s_sy),
        .o_valid(s_qv), .o_q(s_q), .o_sum(s_sum)
    );

    e2q_isqrt u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_qv), .i_sum(s_sum),
        .o_valid(s_rv), .o_root(s_root)
    );

    e2q_delay #(
        .WIDTH($bits(e2q_pkg::t_qraw)),
        .DEPTH(e2q_pkg::LAT_SQRT)
    ) u_qdly (
        .i_clk(i_clk), .i_data(s_q), .o_data(s_q_dly)
    );

    e2q_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_rv), .i_q(s_q_dly),
        .i_norm(s_root), .o_valid(s_dv), .o_q(s_qo)
    );

    e2q_delay #(
        .WIDTH(PW),
        .DEPTH(e2q_pkg::LAT_TOTAL)
    ) u_pdly (
        .i_clk(i_clk), .i_data({i_pose.pos_x, i_pose.pos_y, i_pose.pos_z}),
        .o_data(s_pos_dly)
    );

    assign o_valid       = s_dv;
    assign o_pose.out_x  = s_pos_dly[PW-1 -: e2q_pkg::POS_W];
    assign o_pose.out_y  = s_pos_dly[2*e2q_pkg::POS_W-1 -: e2q_pkg::POS_W];
    assign o_pose.out_z  = s_pos_dly[e2q_pkg::POS_W-1:0];
    assign o_pose.quat_x = s_qo.x;
    assign o_pose.quat_y = s_qo.y;
    assign o_pose.quat_z = s_qo.z;
    assign o_pose.quat_w = s_qo.w;

endmodule

// File: rtl/e2q_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_checker: port-level checks for the pose core
// Checks result timing and x and z position alignment against accepted items.
// ----------------------------------------------------------------------------
module e2q_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input e2q_pkg::t_pose_in  i_pose,
    input logic               o_busy,
    input logic               o_valid,
    input e2q_pkg::t_pose_out o_pose
);

    localparam int LAT = e2q_pkg::LAT_TOTAL;

    a_valid_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, LAT))
        else $error("result strobe without a matching item");

    a_pos_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pose.out_x == $past(i_pose.pos_x, LAT)) &&
                    (o_pose.out_z == $past(i_pose.pos_z, LAT)))
        else $error("position does not belong to the item");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_busy)
        else $error("activity after reset");

endmodule

bind euler_to_quaternion_pose_core e2q_checker u_e2q_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_pose(i_pose),
    .o_busy(o_busy), .o_valid(o_valid), .o_pose(o_pose)
);

// File: tb/tb_euler_to_quaternion_pose_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_to_quaternion_pose_core: pose conversion testbench
// Directed angle extremes followed by random poses are sent through the core
// with random gaps. Each returned pose is checked field by field against a
// bit-exact CORDIC, product, square root and division predictor in queue order.
// ----------------------------------------------------------------------------
module tb_euler_to_quaternion_pose_core;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int N_RANDOM       = 530;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    e2q_pkg::t_pose_in  i_pose = '0;
    logic               o_busy;
    logic               o_valid;
    e2q_pkg::t_pose_out o_pose;

    e2q_pkg::t_pose_in  pending_poses[$];
    e2q_pkg::t_pose_out expected_poses[$];
    int        n_errors = 0;
    int        n_sent = 0;
    int        n_checked = 0;
    int        idle_cycles = 0;
    int        cycle_count = 0;
    int        n_directed = 0;
    bit        stimulus_done = 1'b0;

    euler_to_quaternion_pose_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_pose  (i_pose),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_pose  (o_pose)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void half_angle_sincos(logic [e2q_pkg::ANGLE_W-1:0] code,
                                              output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint atan_steps[e2q_pkg::CORDIC_N] = '{
            'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
            'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
            'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
            'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
            'h00000028, 'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001};
        z = longint'($signed({code, 16'h0000})) >>> 1;
        x = 'h26DD3B6A;
        y = 0;
        for (int i = 0; i < e2q_pkg::CORDIC_N; i++) begin
            dx = shift_floor(y, i);
            dy = shift_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_steps[i];
            end else begin
                x += dx; y -= dy; z += atan_steps[i];
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [e2q_pkg::QUAT_W-1:0] scale_component(longint q,
                                                                   longint unsigned nrm);
        longint unsigned mag;
        longint unsigned r;
        mag = (q < 0) ? longint'(-q) : q;
        r = ((mag << (e2q_pkg::QUAT_W - 1)) + nrm / 2) / nrm;
        if (q >= 0) begin
            if (r > 32767) r = 32767;
            return r[e2q_pkg::QUAT_W-1:0];
        end
        if (r > 32768) r = 32768;
        r = -r;
        return r[e2q_pkg::QUAT_W-1:0];
    endfunction

    function automatic e2q_pkg::t_pose_out predict_pose(e2q_pkg::t_pose_in p);
        e2q_pkg::t_pose_out res;
        longint cr, sr, cp, sp, cy, sy, a, b, c, d, qw, qx, qy, qz;
        longint unsigned nrm;
        half_angle_sincos(p.roll_angle, cr, sr);
        half_angle_sincos(p.pitch_angle, cp, sp);
        half_angle_sincos(p.yaw_angle, cy, sy);
        a = (cp * cy) >>> 30;
        b = (sp * sy) >>> 30;
        c = (sp * cy) >>> 30;
        d = (cp * sy) >>> 30;
        qw = (cr * a + sr * b) >>> 30;
        qx = (sr * a - cr * b) >>> 30;
        qy = (cr * c + sr * d) >>> 30;
        qz = (cr * d - sr * c) >>> 30;
        nrm = floor_sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
        res.out_x = p.pos_x;
        res.out_y = p.pos_y;
        res.out_z = p.pos_z;
        if (nrm == 0) begin
            res.quat_x = '0;
            res.quat_y = '0;
            res.quat_z = '0;
            res.quat_w = 16'sh7FFF;
        end else begin
            res.quat_x = scale_component(qx, nrm);
            res.quat_y = scale_component(qy, nrm);
            res.quat_z = scale_component(qz, nrm);
            res.quat_w = scale_component(qw, nrm);
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 n_checked, field, got, want);
        n_errors++;
    endtask

    function automatic e2q_pkg::t_pose_in random_pose();
        e2q_pkg::t_pose_in p;
        p.pos_x = $urandom;
        p.pos_y = $urandom;
        p.pos_z = $urandom;
        p.roll_angle = 16'($urandom);
        p.pitch_angle = 16'($urandom);
        p.yaw_angle = 16'($urandom);
        return p;
    endfunction

    task automatic add_pose(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [15:0] r, logic [15:0] pt, logic [15:0] yw);
        e2q_pkg::t_pose_in p;
        p = '{x, y, z, r, pt, yw};
        pending_poses.push_back(p);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                expected_poses.push_back(predict_pose(i_pose));
                n_sent++;
            end
            if (!(i_start && o_busy)) begin
                if (pending_poses.size() != 0
                    && ((n_sent >= 150 && n_sent < 300) || $urandom_range(99) >= 22)) begin
                    i_pose  <= pending_poses.pop_front();
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                    if (pending_poses.size() == 0) stimulus_done <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        e2q_pkg::t_pose_out want;
        if (i_rst_n && o_valid) begin
            if (expected_poses.size() == 0) begin
                $display("unexpected result with nothing outstanding");
                n_errors++;
            end else begin
                want = expected_poses.pop_front();
                if (o_pose.out_x !== want.out_x) report_mismatch("out_x", o_pose.out_x, want.out_x);
                if (o_pose.out_y !== want.out_y) report_mismatch("out_y", o_pose.out_y, want.out_y);
                if (o_pose.out_z !== want.out_z) report_mismatch("out_z", o_pose.out_z, want.out_z);
                if (o_pose.quat_x !== want.quat_x)
                    report_mismatch("quat_x", o_pose.quat_x, want.quat_x);
                if (o_pose.quat_y !== want.quat_y)
                    report_mismatch("quat_y", o_pose.quat_y, want.quat_y);
                if (o_pose.quat_z !== want.quat_z)
                    report_mismatch("quat_z", o_pose.quat_z, want.quat_z);
                if (o_pose.quat_w !== want.quat_w)
                    report_mismatch("quat_w", o_pose.quat_w, want.quat_w);
            end
            n_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if ((i_start && !o_busy) || o_valid || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no progress for %0d cycles", idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        add_pose(32'h0, 32'h0, 32'h0, 16'h0000, 16'h0000, 16'h0000);
        add_pose(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 16'h8000, 16'h8000, 16'h8000);
        add_pose(32'h80000000, 32'h7FFFFFFF, 32'h00000001, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        add_pose(32'hAAAAAAAA, 32'h55555555, 32'h12345678, 16'h8000, 16'h0000, 16'h0000);
        add_pose(32'h55555555, 32'hAAAAAAAA, 32'h87654321, 16'h0000, 16'h8000, 16'h0000);
        add_pose(32'h1, 32'h2, 32'h3, 16'h0000, 16'h0000, 16'h8000);
        add_pose(32'h4, 32'h5, 32'h6, 16'h4000, 16'h0000, 16'h0000);
        add_pose(32'h7, 32'h8, 32'h9, 16'h0000, 16'h4000, 16'h0000);
        add_pose(32'hA, 32'hB, 32'hC, 16'h0000, 16'h0000, 16'h4000);
        add_pose(32'hD, 32'hE, 32'hF, 16'hC000, 16'hC000, 16'hC000);
        add_pose(32'h10, 32'h11, 32'h12, 16'h0001, 16'hFFFF, 16'h0001);
        add_pose(32'h13, 32'h14, 32'h15, 16'h2000, 16'h6000, 16'hA000);
        add_pose(32'h16, 32'h17, 32'h18, 16'h7FFF, 16'h8000, 16'h4000);
        add_pose(32'h19, 32'h1A, 32'h1B, 16'h8001, 16'h7FFF, 16'hE000);
        n_directed = pending_poses.size();
        for (int i = 0; i < N_RANDOM; i++) pending_poses.push_back(random_pose());
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done);
        wait (expected_poses.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d poses (%0d directed angle extremes, the rest random), checked %0d.",
                 n_sent, n_directed, n_checked);
        $display("Run took %0d cycles with random and gap-free input stretches.", cycle_count);
        if (n_errors == 0 && expected_poses.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d results never arrived, %0d mismatches",
                     expected_poses.size(), n_errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
